// ===== sv/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_RUN(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/ktn_pkg.sv =====
package ktn_pkg;

  localparam int CP_W = 21;

  typedef enum logic [1:0] {
    REG_IGNORE = 2'd0,
    REG_FOLD   = 2'd1,
    REG_SOUND  = 2'd2,
    REG_SYMBOL = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] ignore_sel;
    logic [2:0] fold_sel;
    logic [5:0] sound_sel;
    logic [2:0] symbol_sel;
  } cfg_t;

  typedef struct packed {
    logic [CP_W-1:0] held;
    logic            held_valid;
    logic [CP_W-1:0] prev_norm;
    logic [CP_W-1:0] prev_raw;
  } ctx_t;

  typedef struct packed {
    logic            eos;
    logic [CP_W-1:0] point;
  } word_t;

endpackage

// ===== sv/ktn_core.sv =====
module ktn_core (
  input  ktn_pkg::cfg_t               cfg,
  input  ktn_pkg::ctx_t               ctx,
  input  logic [ktn_pkg::CP_W-1:0]    code,
  input  logic                        last,
  output ktn_pkg::ctx_t               ctx_next,
  output ktn_pkg::word_t              word0,
  output ktn_pkg::word_t              word1,
  output ktn_pkg::word_t              word2,
  output logic [1:0]                  count
);

  typedef struct packed {
    logic                     emit;
    logic [ktn_pkg::CP_W-1:0] res;
    logic [ktn_pkg::CP_W-1:0] pn;
    logic [ktn_pkg::CP_W-1:0] pr;
  } proc_t;

  function automatic logic [20:0] single_fold(input ktn_pkg::cfg_t k, input logic [20:0] c_in);
    logic [20:0] c;
    c = c_in;
    if (k.fold_sel[1] && c >= 21'h3041 && c <= 21'h3094) begin
      c = c + 21'h0060;
    end
    if (k.fold_sel[2]) begin
      case (c)
        21'h30c3: c = 21'h30c4;
        21'h30e3: c = 21'h30e4;
        21'h30e5: c = 21'h30e6;
        21'h30e7: c = 21'h30e8;
        21'h3063: c = 21'h3064;
        21'h3083: c = 21'h3084;
        21'h3085: c = 21'h3086;
        21'h3087: c = 21'h3088;
        default: c = c;
      endcase
    end
    return c;
  endfunction

  function automatic logic is_ignored(input ktn_pkg::cfg_t k, input logic [20:0] c);
    logic ws;
    logic pu;
    ws = c == 21'h09 || c == 21'h0a || c == 21'h0d || c == 21'h20 || c == 21'ha0 ||
         (c >= 21'h2000 && c <= 21'h200a) || c == 21'h202f || c == 21'h205f ||
         c == 21'h3000;
    pu = (c >= 21'h21 && c <= 21'h2f) || (c >= 21'h3a && c <= 21'h40) ||
         (c >= 21'h5b && c <= 21'h60) || (c >= 21'h7b && c <= 21'h7e) ||
         (c >= 21'ha1 && c <= 21'hbf) || (c >= 21'h2016 && c <= 21'h2027) ||
         (c >= 21'h2030 && c <= 21'h2057) || (c >= 21'h3001 && c <= 21'h3011) ||
         (c >= 21'h3014 && c <= 21'h3020);
    return (k.ignore_sel[0] && ws) || (k.ignore_sel[1] && pu);
  endfunction

  function automatic logic [20:0] fold_main(input ktn_pkg::cfg_t k, input logic [20:0] c,
                                            input logic [20:0] n);
    logic [20:0] v;
    logic        sa_row;
    sa_row = n == 21'h30b5 || n == 21'h30b7 || n == 21'h30b9 || n == 21'h30bb ||
             n == 21'h30bd;
    priority if (k.fold_sel[0] && c >= 21'h61 && c <= 21'h7a) begin
      v = c - 21'h20;
    end else if (k.fold_sel[0] && c >= 21'hff41 && c <= 21'hff5a) begin
      v = c - 21'h20;
    end else if (k.sound_sel[0] && c == 21'h30c2) begin
      v = 21'h30b8;
    end else if (k.sound_sel[0] && c == 21'h30c5) begin
      v = 21'h30ba;
    end else if (k.sound_sel[1] && c == 21'h30f4 && n == 21'h30a1) begin
      v = 21'h30d0;
    end else if (k.sound_sel[1] && c == 21'h30f4 && n == 21'h30a3) begin
      v = 21'h30d3;
    end else if (k.sound_sel[1] && c == 21'h30f4 && n == 21'h30a7) begin
      v = 21'h30d9;
    end else if (k.sound_sel[1] && c == 21'h30f4 && n == 21'h30a9) begin
      v = 21'h30dc;
    end else if (k.sound_sel[2] && n == 21'h30a3 && (c == 21'h30c4 || c == 21'h30c6)) begin
      v = 21'h30c1;
    end else if (k.sound_sel[2] && n == 21'h30a3 && c == 21'h30c7) begin
      v = 21'h30b8;
    end else if (k.sound_sel[3] && n == 21'h30a7 && c == 21'h30b7) begin
      v = 21'h30bb;
    end else if (k.sound_sel[3] && n == 21'h30a7 && c == 21'h30b8) begin
      v = 21'h30bc;
    end else if (((k.sound_sel[4] && n == 21'h30e5) ||
                  ((k.sound_sel[4] || k.fold_sel[2]) && n == 21'h30e6)) &&
                 c == 21'h30d5) begin
      v = 21'h30d2;
    end else if (((k.sound_sel[4] && n == 21'h30e5) ||
                  ((k.sound_sel[4] || k.fold_sel[2]) && n == 21'h30e6)) &&
                 c == 21'h30f4) begin
      v = 21'h30d3;
    end else if (k.sound_sel[5] && c == 21'h30af && sa_row) begin
      v = 21'h30ad;
    end else if (k.symbol_sel[0] && (c == 21'had || (c >= 21'h2010 && c <= 21'h2015) ||
                 c == 21'h2212 || c == 21'h30fc || c == 21'hff0d)) begin
      v = 21'h002d;
    end else if (k.symbol_sel[1] && (c == 21'h4e2a || c == 21'h30f6 || c == 21'h30f5)) begin
      v = 21'h7b87;
    end else begin
      v = c;
    end
    return v;
  endfunction

  function automatic logic vowel_dropped(input ktn_pkg::cfg_t k, input logic [20:0] p,
                                         input logic [20:0] c);
    logic a;
    logic b;
    logic d;
    a = k.sound_sel[1] && p == 21'h30f4 &&
        (c == 21'h30a1 || c == 21'h30a3 || c == 21'h30a7 || c == 21'h30a9);
    b = k.sound_sel[2] && c == 21'h30a3 &&
        (p == 21'h30c4 || p == 21'h30c6 || p == 21'h30c7);
    d = k.sound_sel[3] && c == 21'h30a7 && (p == 21'h30b7 || p == 21'h30b8);
    return a || b || d;
  endfunction

  function automatic logic [20:0] ya_rule(input ktn_pkg::cfg_t k, input logic [20:0] p,
                                          input logic [20:0] c);
    logic i_row;
    i_row = p == 21'h30a4 || p == 21'h30ad || p == 21'h30ae || p == 21'h30b7 ||
            p == 21'h30b8 || p == 21'h30c1 || p == 21'h30c2 || p == 21'h30cb ||
            p == 21'h30d2 || p == 21'h30d3 || p == 21'h30d4 || p == 21'h30df ||
            p == 21'h30ea || p == 21'h30f0;
    return (k.symbol_sel[2] && c == 21'h30e4 && i_row) ? 21'h30a2 : c;
  endfunction

  function automatic proc_t process(input ktn_pkg::cfg_t k, input logic [20:0] h,
                                    input logic [20:0] n, input logic [20:0] pn,
                                    input logic [20:0] pr);
    proc_t       o;
    logic [20:0] v;
    v = fold_main(k, h, n);
    if (is_ignored(k, h)) begin
      o.emit = 1'b0;
      o.res  = v;
      o.pn   = h;
      o.pr   = h;
    end else begin
      o.emit = !vowel_dropped(k, pr, v);
      o.res  = ya_rule(k, pn, v);
      o.pn   = v;
      o.pr   = h;
    end
    return o;
  endfunction

  logic [ktn_pkg::CP_W-1:0] f;
  proc_t                    p1;
  proc_t                    p2;
  logic                     e1;
  logic                     e2;
  ktn_pkg::word_t           w_r1;
  ktn_pkg::word_t           w_r2;
  ktn_pkg::word_t           w_end;

  always_comb begin
    f  = single_fold(cfg, code);
    p1 = process(cfg, ctx.held, f, ctx.prev_norm, ctx.prev_raw);
    e1 = ctx.held_valid && p1.emit;
    if (!ctx.held_valid) begin
      p1.pn = ctx.prev_norm;
      p1.pr = ctx.prev_raw;
    end
    p2 = process(cfg, f, '0, p1.pn, p1.pr);
    e2 = p2.emit;

    w_r1  = '{eos: 1'b0, point: p1.res};
    w_r2  = '{eos: 1'b0, point: p2.res};
    w_end = '{eos: 1'b1, point: '0};

    if (last) begin
      // string done: back to the reset context
      ctx_next = '0;
      word0    = e1 ? w_r1 : (e2 ? w_r2 : w_end);
      word1    = (e1 && e2) ? w_r2 : w_end;
      word2    = w_end;
      count    = 2'd1 + {1'b0, e1} + {1'b0, e2};
    end else begin
      ctx_next = '{held: f, held_valid: 1'b1, prev_norm: p1.pn, prev_raw: p1.pr};
      word0    = w_r1;
      word1    = w_end;
      word2    = w_end;
      count    = {1'b0, e1};
    end
  end

endmodule

// ===== sv/kana_text_normalizer_unit.sv =====
// timing: a character's result is output once the word that follows it leaves the input stage,
//   the last character of a string together with that final word
// throughput: one word per cycle while m_tready is high; a final word yields up to
//   three output words, sent one per cycle as taken, while at most one input word waits
// reset: rst clears configuration, held context, input stage and result buffer
module kana_text_normalizer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [20:0] code_point, [23:21] zero
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] norm_point, [23:21] zero
  output logic        m_tlast,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_wdata
);

  ktn_pkg::cfg_t            cfg;
  ktn_pkg::ctx_t            ctx;
  ktn_pkg::ctx_t            ctx_next;
  logic                     in_full;
  logic [ktn_pkg::CP_W-1:0] in_cp;
  logic                     in_last;
  ktn_pkg::word_t           buf0;
  ktn_pkg::word_t           buf1;
  ktn_pkg::word_t           buf2;
  logic [1:0]               cnt;
  ktn_pkg::word_t           w0;
  ktn_pkg::word_t           w1;
  ktn_pkg::word_t           w2;
  logic [1:0]               w_cnt;
  logic                     out_take;
  logic                     load_ok;
  logic                     fire;
  logic                     in_take;

  ktn_core u_core (
    .cfg      (cfg),
    .ctx      (ctx),
    .code     (in_cp),
    .last     (in_last),
    .ctx_next (ctx_next),
    .word0    (w0),
    .word1    (w1),
    .word2    (w2),
    .count    (w_cnt)
  );

  assign m_tvalid = cnt != 2'd0;
  assign m_tdata  = {3'b000, buf0.point};
  assign m_tlast  = buf0.eos;
  assign out_take = m_tvalid && m_tready;
  assign load_ok  = (cnt == 2'd0) || (cnt == 2'd1 && m_tready);
  assign fire     = in_full && load_ok;
  assign s_tready = !in_full || fire;
  assign in_take  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg     <= '0;
      ctx     <= '0;
      in_full <= 1'b0;
      cnt     <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        unique case (ktn_pkg::reg_idx_t'(cfg_index))
          ktn_pkg::REG_IGNORE: cfg.ignore_sel <= cfg_wdata[1:0];
          ktn_pkg::REG_FOLD:   cfg.fold_sel   <= cfg_wdata[2:0];
          ktn_pkg::REG_SOUND:  cfg.sound_sel  <= cfg_wdata[5:0];
          ktn_pkg::REG_SYMBOL: cfg.symbol_sel <= cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (in_take) begin
        in_full <= 1'b1;
      end else if (fire) begin
        in_full <= 1'b0;
      end
      if (fire) begin
        ctx <= ctx_next;
        cnt <= w_cnt;
      end else if (out_take) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_cp   <= s_tdata[20:0];
      in_last <= s_tlast;
    end
    if (fire) begin
      buf0 <= w0;
      buf1 <= w1;
      buf2 <= w2;
    end else if (out_take) begin
      buf0 <= buf1;
      buf1 <= buf2;
    end
  end

endmodule

// ===== sv/ktn_checker.sv =====
`include "assert_macros.svh"

module ktn_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast
);

  logic unused_in;
  assign unused_in = s_tvalid ^ s_tlast ^ (^s_tdata);

  `ASSERT_RUN(a_hold_payload, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output word changed")
  `ASSERT_RUN(a_end_zero, clk, rst, m_tvalid && m_tlast |-> m_tdata == 24'd0, "end marker with nonzero point")
  `ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> !m_tvalid, "output valid right after reset")
  `ASSERT_RUN(a_stall_cause, clk, rst, !s_tready |-> m_tvalid, "input stalled with empty output")

endmodule

bind kana_text_normalizer_unit ktn_checker u_ktn_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== test/kana_text_normalizer_unit_tb.sv =====
`timescale 1ns / 1ps

module kana_text_normalizer_unit_tb;

  typedef logic [ktn_pkg::CP_W-1:0] cp_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LAST_FLAG = 32'h0020_0000;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 42;

  class norm_scoreboard;
    ktn_pkg::cfg_t  cfg;
    cp_t            held;
    bit             held_valid;
    cp_t            prev_norm;
    cp_t            prev_raw;
    ktn_pkg::word_t pending_norm[$];
    int             errors;

    function new();
      cfg = '0;
      held = '0;
      held_valid = 1'b0;
      prev_norm = '0;
      prev_raw = '0;
      errors = 0;
    endfunction

    function void set_reg(ktn_pkg::reg_idx_t idx, logic [5:0] v);
      case (idx)
        ktn_pkg::REG_IGNORE: cfg.ignore_sel = v[1:0];
        ktn_pkg::REG_FOLD:   cfg.fold_sel = v[2:0];
        ktn_pkg::REG_SOUND:  cfg.sound_sel = v[5:0];
        ktn_pkg::REG_SYMBOL: cfg.symbol_sel = v[2:0];
        default: ;
      endcase
    endfunction

    // hiragana to katakana, then small tsu, ya, yu, yo to large, each under its fold_sel bit
    function cp_t fold_single(cp_t c);
      cp_t f;
      f = c;
      if (cfg.fold_sel[1] && f >= 21'h3041 && f <= 21'h3094) f = f - 21'h3041 + 21'h30a1;
      if (cfg.fold_sel[2]) begin
        case (f)
          21'h30c3, 21'h30e3, 21'h30e5, 21'h30e7,
          21'h3063, 21'h3083, 21'h3085, 21'h3087: f = f + 21'h1;
          default: ;
        endcase
      end
      return f;
    endfunction

    function bit is_skipped(cp_t c);
      bit ws;
      bit pu;
      ws = c inside {21'h09, 21'h0a, 21'h0d, 21'h20, 21'ha0, [21'h2000:21'h200a],
                     21'h202f, 21'h205f, 21'h3000};
      pu = c inside {[21'h21:21'h2f], [21'h3a:21'h40], [21'h5b:21'h60], [21'h7b:21'h7e],
                     [21'ha1:21'hbf], [21'h2016:21'h2027], [21'h2030:21'h2057],
                     [21'h3001:21'h3011], [21'h3014:21'h3020]};
      return (cfg.ignore_sel[0] && ws) || (cfg.ignore_sel[1] && pu);
    endfunction

    function cp_t fold_char(cp_t c, cp_t n);
      if (cfg.fold_sel[0]) begin
        if (c inside {[21'h61:21'h7a]}) return c - 21'h20;
        if (c inside {[21'hff41:21'hff5a]}) return c - 21'h20;
      end
      if (cfg.sound_sel[0]) begin
        if (c == 21'h30c2) return 21'h30b8;
        if (c == 21'h30c5) return 21'h30ba;
      end
      if (cfg.sound_sel[1] && c == 21'h30f4) begin
        if (n == 21'h30a1) return 21'h30d0;
        if (n == 21'h30a3) return 21'h30d3;
        if (n == 21'h30a7) return 21'h30d9;
        if (n == 21'h30a9) return 21'h30dc;
      end
      if (cfg.sound_sel[2] && n == 21'h30a3) begin
        if (c == 21'h30c4 || c == 21'h30c6) return 21'h30c1;
        if (c == 21'h30c7) return 21'h30b8;
      end
      if (cfg.sound_sel[3] && n == 21'h30a7) begin
        if (c == 21'h30b7) return 21'h30bb;
        if (c == 21'h30b8) return 21'h30bc;
      end
      if ((cfg.sound_sel[4] && n == 21'h30e5) ||
          ((cfg.sound_sel[4] || cfg.fold_sel[2]) && n == 21'h30e6)) begin
        if (c == 21'h30d5) return 21'h30d2;
        if (c == 21'h30f4) return 21'h30d3;
      end
      if (cfg.sound_sel[5] && c == 21'h30af &&
          n inside {21'h30b5, 21'h30b7, 21'h30b9, 21'h30bb, 21'h30bd})
        return 21'h30ad;
      if (cfg.symbol_sel[0] &&
          c inside {21'had, [21'h2010:21'h2015], 21'h2212, 21'h30fc, 21'hff0d})
        return 21'h002d;
      if (cfg.symbol_sel[1] && c inside {21'h4e2a, 21'h30f6, 21'h30f5}) return 21'h7b87;
      return c;
    endfunction

    function bit drops_vowel(cp_t p, cp_t c);
      return (cfg.sound_sel[1] && p == 21'h30f4 &&
              c inside {21'h30a1, 21'h30a3, 21'h30a7, 21'h30a9}) ||
             (cfg.sound_sel[2] && c == 21'h30a3 && p inside {21'h30c4, 21'h30c6, 21'h30c7}) ||
             (cfg.sound_sel[3] && c == 21'h30a7 && p inside {21'h30b7, 21'h30b8});
    endfunction

    function cp_t ya_to_a(cp_t p, cp_t c);
      if (cfg.symbol_sel[2] && c == 21'h30e4 &&
          p inside {21'h30a4, 21'h30ad, 21'h30ae, 21'h30b7, 21'h30b8, 21'h30c1, 21'h30c2,
                    21'h30cb, 21'h30d2, 21'h30d3, 21'h30d4, 21'h30df, 21'h30ea, 21'h30f0})
        return 21'h30a2;
      return c;
    endfunction

    function bit normalize_char(cp_t h, cp_t n, output cp_t res);
      cp_t v;
      bit emit;
      emit = 1'b0;
      res = '0;
      if (is_skipped(h)) begin
        prev_norm = h;
        prev_raw = h;
        return 1'b0;
      end
      v = fold_char(h, n);
      if (!drops_vowel(prev_raw, v)) begin
        res = ya_to_a(prev_norm, v);
        emit = 1'b1;
      end
      prev_norm = v;
      prev_raw = h;
      return emit;
    endfunction

    function void note_char(cp_t c, bit is_last);
      cp_t f;
      cp_t r;
      f = fold_single(c);
      if (held_valid && normalize_char(held, f, r))
        pending_norm.push_back(ktn_pkg::word_t'{eos: 1'b0, point: r});
      if (is_last) begin
        if (normalize_char(f, '0, r))
          pending_norm.push_back(ktn_pkg::word_t'{eos: 1'b0, point: r});
        pending_norm.push_back(ktn_pkg::word_t'{eos: 1'b1, point: '0});
        held = '0;
        held_valid = 1'b0;
        prev_norm = '0;
        prev_raw = '0;
      end else begin
        held = f;
        held_valid = 1'b1;
      end
    endfunction

    function void check_word(logic [23:0] data, logic eos);
      ktn_pkg::word_t w;
      if (pending_norm.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual tdata=%h tlast=%b",
                 $time, data, eos);
        errors++;
        return;
      end
      w = pending_norm.pop_front();
      if (data !== {3'b000, w.point}) begin
        $display("%0t: tdata mismatch, expected %h actual %h", $time, {3'b000, w.point}, data);
        errors++;
      end
      if (eos !== w.eos) begin
        $display("%0t: tlast mismatch, expected %b actual %b", $time, w.eos, eos);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [5:0]  cfg_wdata;

  norm_scoreboard sb = new();

  int burst_left = 0;
  int gap_max = 6;
  bit hold_request = 1'b0;

  cp_t specials[$] = '{
    21'h3041, 21'h3094, 21'h3063, 21'h3083, 21'h3085, 21'h3087, 21'h30c3, 21'h30e3,
    21'h30e5, 21'h30e7, 21'h30c2, 21'h30c5, 21'h30f4, 21'h30c4, 21'h30c6, 21'h30c7,
    21'h30b7, 21'h30b8, 21'h30d5, 21'h30af, 21'h30b5, 21'h30b9, 21'h30bd, 21'h30a1,
    21'h30a3, 21'h30a7, 21'h30a9, 21'h30e4, 21'h30e6, 21'h30a4, 21'h30ad, 21'h30ae,
    21'h30cb, 21'h30d4, 21'h30df, 21'h30ea, 21'h30f0, 21'h30fc, 21'h4e2a, 21'h30f6,
    21'h30f5, 21'h00ad, 21'h2010, 21'h2015, 21'h2212, 21'hff0d, 21'h0020, 21'h0009,
    21'h000a, 21'h000d, 21'h00a0, 21'h2000, 21'h200a, 21'h202f, 21'h205f, 21'h3000,
    21'h0021, 21'h002f, 21'h003a, 21'h0040, 21'h005b, 21'h0060, 21'h007b, 21'h007e,
    21'h00a1, 21'h00bf, 21'h2016, 21'h2027, 21'h2030, 21'h2057, 21'h3001, 21'h3011,
    21'h3014, 21'h3020, 21'h0061, 21'h007a, 21'hff41, 21'hff5a, 21'h30d2, 21'h30d3,
    21'h30c1, 21'h30bb, 21'h30bc, 21'h0000};

  cp_t heads[$] = '{
    21'h30f4, 21'h30c4, 21'h30c6, 21'h30c7, 21'h30b7, 21'h30b8, 21'h30d5, 21'h30af,
    21'h30ad, 21'h30a4, 21'h30c1, 21'h30cb, 21'h30d2, 21'h30d3, 21'h30df, 21'h30ea,
    21'h30f0, 21'h30ae, 21'h30d4, 21'h30c2};

  cp_t tails[$] = '{
    21'h30a1, 21'h30a3, 21'h30a7, 21'h30a9, 21'h30e5, 21'h30e6, 21'h30e4, 21'h30e3,
    21'h30b5, 21'h30b7, 21'h30b9, 21'h30bb, 21'h30bd};

  int directed_items[$] = '{
    32'h3041, 32'h3094, LAST_FLAG | 32'h3063,
    32'h0020, 32'h0021, 32'h0061, 32'h007a, LAST_FLAG | 32'hff41,
    32'h30c2, 32'h30c5, 32'h30f4, LAST_FLAG | 32'h30a1,
    32'h30c4, 32'h30a3, 32'h30b7, LAST_FLAG | 32'h30a7,
    32'h30d5, LAST_FLAG | 32'h3085,
    32'h30af, 32'h30b5, 32'h30fc, 32'h4e2a, 32'h30ad, LAST_FLAG | 32'h30e4,
    32'h0000, LAST_FLAG | 32'h1fffff};

  kana_text_normalizer_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic cp_t kana_variant(cp_t c);
    if (c >= 21'h30a1 && c <= 21'h30f4 && $urandom_range(0, 3) == 0) return c - 21'h60;
    return c;
  endfunction

  function automatic cp_t random_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return specials[$urandom_range(0, specials.size() - 1)];
    if (r < 60) return cp_t'($urandom_range(32'h3041, 32'h30ff));
    if (r < 75) return cp_t'($urandom_range(0, 255));
    if (r < 82) return cp_t'($urandom_range(32'h2000, 32'h2060));
    if (r < 88) return cp_t'($urandom_range(32'hff00, 32'hff60));
    return cp_t'($urandom_range(0, 32'h1fffff));
  endfunction

  task automatic write_reg(ktn_pkg::reg_idx_t idx, logic [5:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic apply_config(logic [5:0] ign, logic [5:0] fld, logic [5:0] snd,
                              logic [5:0] sym);
    write_reg(ktn_pkg::REG_IGNORE, ign);
    write_reg(ktn_pkg::REG_FOLD, fld);
    write_reg(ktn_pkg::REG_SOUND, snd);
    write_reg(ktn_pkg::REG_SYMBOL, sym);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic offer_char(cp_t c, bit is_last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, c};
    s_tlast <= is_last;
    do @(posedge clk); while (!s_tready);
    sb.note_char(c, is_last);
    burst_left--;
  endtask

  task automatic drain_words();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending_norm.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int hold_left;
    int mode_left;
    int rx_mode;
    int rx_count;
    hold_left = 0;
    mode_left = 0;
    rx_mode = 0;
    rx_count = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      rx_count++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ((rx_count % 8) < 5);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int  phase_items;
    int  len;
    cp_t chars[$];
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = ktn_pkg::REG_IGNORE;
    cfg_wdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    apply_config(6'd3, 6'd7, 6'd63, 6'd7);
    foreach (directed_items[i])
      offer_char(cp_t'(directed_items[i][20:0]), directed_items[i][21]);
    drain_words();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: apply_config(6'd0, 6'd0, 6'd0, 6'd0);
        1: apply_config(6'd3, 6'd7, 6'd63, 6'd7);
        default: apply_config(6'($urandom_range(0, 3)), 6'($urandom_range(0, 7)),
                              6'($urandom_range(0, 63)), 6'($urandom_range(0, 7)));
      endcase
      gap_max = (phase % 4 == 2) ? 0 : 6;
      if (phase == 3) hold_request = 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        chars.delete();
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 8);
        while (chars.size() < len) begin
          if ($urandom_range(0, 99) < 45) begin
            chars.push_back(kana_variant(heads[$urandom_range(0, heads.size() - 1)]));
            chars.push_back(kana_variant(tails[$urandom_range(0, tails.size() - 1)]));
          end else begin
            chars.push_back(random_char());
          end
        end
        foreach (chars[i]) offer_char(chars[i], i == chars.size() - 1);
        phase_items += chars.size();
      end
      drain_words();
    end

    if (sb.errors == 0 && sb.pending_norm.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== kana_text_normalizer_unit.f =====
+incdir+sv
sv/ktn_pkg.sv
sv/ktn_core.sv
sv/kana_text_normalizer_unit.sv
sv/ktn_checker.sv
test/kana_text_normalizer_unit_tb.sv
